// ----- sv/mbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the escape count unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int MBE_FRAC_BITS  = 60;   // default fraction bits of c and z
	localparam int MBE_W          = 64;   // width of c and z
	localparam int MBE_HALF_W     = 32;   // width of one multiplier operand
	localparam int MBE_ACC_W      = 128;  // width of an exact product
	localparam int MBE_CNT_W      = 8;    // width of the iteration count
	localparam int MBE_STEP_W     = 4;    // partial product step counter
	localparam int MBE_PHASE_W    = 2;
	localparam int MBE_PART_W     = 2;
	localparam logic [MBE_CNT_W-1:0] MBE_LIMIT_RESET = 8'd128;

	// Twelve partial products per iteration: three 64x64 products, four each.
	localparam logic [MBE_STEP_W-1:0] MBE_STEP_LAST = 4'd11;

	// Which product a partial product belongs to.
	localparam logic [MBE_PHASE_W-1:0] PH_RR = 2'd0;  // zr * zr
	localparam logic [MBE_PHASE_W-1:0] PH_II = 2'd1;  // zi * zi
	localparam logic [MBE_PHASE_W-1:0] PH_RI = 2'd2;  // zr * zi

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_EVAL,
		ST_DIFF,
		ST_ADD,
		ST_MAG
	} mbe_state_t;

	typedef struct packed {
		logic                  load;   // take a new point, clear z
		logic                  issue;  // start one partial product
		logic [MBE_STEP_W-1:0] step;   // which partial product
		logic                  diff;   // form the rounded new z before adding c
		logic                  add;    // add c and check for a huge z
		logic                  mag;    // take the magnitudes of the new z
	} mbe_ctl_t;

	typedef struct packed {
		logic esc;  // escape is certain at this test
		logic big;  // the last update produced a huge z
	} mbe_sts_t;

endpackage

// ----- sv/mbe_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_core
// Datapath: one shared 32x32 multiplier, product accumulators, update of z.
// ----------------------------------------------------------------------------
module mbe_core
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS = MBE_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mbe_ctl_t         ctl,
	input  logic [MBE_W-1:0] c_re,
	input  logic [MBE_W-1:0] c_im,
	output mbe_sts_t         sts
);

	localparam int THR_BIT = 2 * FRAC_BITS + 2;  // 4.0 in the squared scale

	logic [MBE_W-1:0]      cr_q, ci_q, zr_q, zi_q, mr_q, mi_q, a_q, b_q;
	logic                  big_q;
	logic [MBE_ACC_W-1:0]  rr_q, ii_q, ri_q;

	logic [MBE_PHASE_W-1:0] op_phase;
	logic [MBE_PART_W-1:0]  op_part;
	logic [MBE_W-1:0]       op_a, op_b;
	logic [MBE_HALF_W-1:0]  half_a, half_b;
	logic [MBE_W-1:0]       pp_s1;
	logic [MBE_STEP_W-1:0]  tag_s1;
	logic                   vld_s1;

	logic [MBE_PHASE_W-1:0] acc_phase;
	logic [MBE_PART_W-1:0]  acc_part;
	logic [1:0]             acc_shift;
	logic [MBE_ACC_W-1:0]   acc_cur, acc_base, acc_pp, acc_sum;

	logic [MBE_ACC_W-1:0]   sq_sum, dif, dbl, dbl_n;
	logic [MBE_W-1:0]       sr, si;

	// Signed overflow of a + c, or a sum of magnitude 2.0 or more.
	function automatic logic huge(input logic [MBE_W-1:0] a, input logic [MBE_W-1:0] c,
			input logic [MBE_W-1:0] s);
		logic ovf;
		logic small_neg;
		logic oversize;
		ovf       = (a[MBE_W-1] == c[MBE_W-1]) && (s[MBE_W-1] != a[MBE_W-1]);
		small_neg = (&s[MBE_W-1:FRAC_BITS+1]) && (|s[FRAC_BITS:0]);
		oversize  = s[MBE_W-1] ? !small_neg : (|s[MBE_W-1:FRAC_BITS+1]);
		return ovf || oversize;
	endfunction

	// Operand selection for the shared multiplier.
	assign op_phase = ctl.step[MBE_STEP_W-1:MBE_PART_W];
	assign op_part  = ctl.step[MBE_PART_W-1:0];

	always_comb begin
		case (op_phase)
			PH_RR: begin
				op_a = mr_q;
				op_b = mr_q;
			end
			PH_II: begin
				op_a = mi_q;
				op_b = mi_q;
			end
			default: begin
				op_a = mr_q;
				op_b = mi_q;
			end
		endcase
		half_a = op_part[1] ? op_a[MBE_W-1:MBE_HALF_W] : op_a[MBE_HALF_W-1:0];
		half_b = op_part[0] ? op_b[MBE_W-1:MBE_HALF_W] : op_b[MBE_HALF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1  <= MBE_W'(half_a) * MBE_W'(half_b);
		tag_s1 <= ctl.step;
	end

	// Accumulation of the registered partial product at offset 0, 32 or 64.
	assign acc_phase = tag_s1[MBE_STEP_W-1:MBE_PART_W];
	assign acc_part  = tag_s1[MBE_PART_W-1:0];
	assign acc_shift = {1'b0, acc_part[1]} + {1'b0, acc_part[0]};

	always_comb begin
		case (acc_phase)
			PH_RR:   acc_cur = rr_q;
			PH_II:   acc_cur = ii_q;
			default: acc_cur = ri_q;
		endcase
		case (acc_shift)
			2'd0:    acc_pp = {{MBE_W{1'b0}}, pp_s1};
			2'd1:    acc_pp = {{MBE_HALF_W{1'b0}}, pp_s1, {MBE_HALF_W{1'b0}}};
			2'd2:    acc_pp = {pp_s1, {MBE_W{1'b0}}};
			default: acc_pp = '0;
		endcase
		acc_base = (acc_part == '0) ? '0 : acc_cur;
		acc_sum  = acc_base + acc_pp;
	end

	// Escape test and rounded update terms.
	assign sq_sum = rr_q + ii_q;
	assign dif    = rr_q - ii_q;
	assign dbl    = {ri_q[MBE_ACC_W-2:0], 1'b0};
	assign dbl_n  = (zr_q[MBE_W-1] ^ zi_q[MBE_W-1]) ? (~dbl + 1'b1) : dbl;
	assign sr     = a_q + cr_q;
	assign si     = b_q + ci_q;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			case (acc_phase)
				PH_RR:   rr_q <= acc_sum;
				PH_II:   ii_q <= acc_sum;
				default: ri_q <= acc_sum;
			endcase
		end
		if (ctl.load) begin
			cr_q  <= c_re;
			ci_q  <= c_im;
			zr_q  <= '0;
			zi_q  <= '0;
			mr_q  <= '0;
			mi_q  <= '0;
			big_q <= 1'b0;
		end
		if (ctl.diff) begin
			a_q <= dif[FRAC_BITS+MBE_W-1:FRAC_BITS];
			b_q <= dbl_n[FRAC_BITS+MBE_W-1:FRAC_BITS];
		end
		if (ctl.add) begin
			zr_q  <= sr;
			zi_q  <= si;
			big_q <= big_q | huge(a_q, cr_q, sr) | huge(b_q, ci_q, si);
		end
		if (ctl.mag) begin
			mr_q <= zr_q[MBE_W-1] ? (~zr_q + 1'b1) : zr_q;
			mi_q <= zi_q[MBE_W-1] ? (~zi_q + 1'b1) : zi_q;
		end
	end

	assign sts.big = big_q;
	assign sts.esc = big_q || (|sq_sum[MBE_ACC_W-1:THR_BIT]);

endmodule

// ----- sv/mandelbrot_escape_count_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_unit
// Escape time counter for one complex point of the Mandelbrot iteration.
// ----------------------------------------------------------------------------
// The unit takes one point c (c_real, c_imag, signed fixed point with
// FRAC_BITS fraction bits in 64 bits) per input word and iterates
// z = z*z + c from z = 0. Before each iteration it checks |z|^2 >= 4; when
// that holds the result word carries the count so far and escaped = 1.
// Otherwise, once the count has reached max_iterations, the result carries
// the count and escaped = 0. When both hold at once the point is reported as
// escaped, and a limit of zero gives count 0 and escaped 0. Squares and the
// cross product are kept exact at 128 bits and floored once to FRAC_BITS, so
// nothing wraps before the escape test; a new z of magnitude 2.0 or more, or
// one that overflows when c is added, is flagged and escapes at the next test.
// All products go through one shared 32x32 multiplier: each iteration runs
// twelve partial products, then the drain, test, difference, add and
// magnitude states. The default limit is 128. A point whose new z turns huge
// skips the last round of products and the drain. The unit works on one point
// at a time and holds in_stall high until that point's result is in the
// output register; a result waiting there does not keep the next point from
// being accepted. max_iterations is written through cfg_we and cfg_wdata and
// should be changed only while the unit is idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_unit
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS = MBE_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_we,
	input  logic [MBE_CNT_W-1:0]    cfg_wdata,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [MBE_W-1:0] c_real,
	input  logic signed [MBE_W-1:0] c_imag,

	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [MBE_CNT_W-1:0]    iteration_count,
	output logic                    escaped
);

	mbe_state_t state_q, state_d;
	logic [MBE_STEP_W-1:0] step_q;
	logic [MBE_CNT_W-1:0]  n_q, max_q;
	logic                  out_valid_q;
	logic [MBE_CNT_W-1:0]  count_q;
	logic                  esc_q;

	mbe_ctl_t ctl;
	mbe_sts_t sts;
	logic     accept;
	logic     finish;
	logic     slot_free;
	logic     emit;

	mbe_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.c_re  ($unsigned(c_real)),
		.c_im  ($unsigned(c_imag)),
		.sts   (sts)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	// The point is done when escape is certain or the count has hit the limit.
	assign finish    = sts.esc || (n_q >= max_q);
	// The output register can take a new word if it is empty or being drained.
	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_EVAL) && finish && slot_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == MBE_STEP_LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				// A finished point waits here while the output register is full.
				if (finish) begin
					if (slot_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				// A huge z skips the products: the next test escapes on the flag.
				state_d = ST_MAG;
			end
			ST_MAG: begin
				state_d = sts.big ? ST_EVAL : ST_MUL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath controls.
	always_comb begin
		ctl       = '0;
		ctl.step  = step_q;
		case (state_q)
			ST_IDLE:  ctl.load  = accept;
			ST_MUL:   ctl.issue = 1'b1;
			ST_DIFF:  ctl.diff  = 1'b1;
			ST_ADD:   ctl.add   = 1'b1;
			ST_MAG:   ctl.mag   = 1'b1;
			default:  ctl       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			n_q         <= '0;
			max_q       <= MBE_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) max_q <= cfg_wdata;
			if (state_q == ST_MUL) begin
				step_q <= (step_q == MBE_STEP_LAST) ? '0 : step_q + 1'b1;
			end
			if (accept) begin
				n_q <= '0;
			end else if (state_q == ST_ADD) begin
				n_q <= n_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			count_q <= n_q;
			esc_q   <= sts.esc;
		end
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = count_q;
	assign escaped         = esc_q;

endmodule
